>>> sv/bta_pkg.sv
// Shared types and constants for the boundary-tag first-fit allocator.
// No dependencies; every other file refers to it by scoped names.
package bta_pkg;

   localparam int MEM_BYTES  = 4096;
   localparam int TAG_BYTES  = 9;
   localparam int SIZE_BYTES = TAG_BYTES - 1;
   localparam int ADDR_W     = $clog2(MEM_BYTES);
   localparam int VAL_W      = 13;
   localparam int DATA_W     = 32;

   localparam logic [VAL_W-1:0] ARENA_RESET = VAL_W'(MEM_BYTES);
   localparam logic [VAL_W-1:0] ARENA_MIN   = VAL_W'(2 * TAG_BYTES);

   // configuration register indexes
   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_ARENA = 1'b1;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] y;
      logic              borrow;
   } alu_res_type;

endpackage

>>> sv/bta_if.sv
// Handshake channels of the allocator: request and response.
// Depends on bta_pkg for field widths.
interface bta_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [bta_pkg::VAL_W-1:0]   request_size;
   logic [bta_pkg::DATA_W-1:0]  block_address;

   modport source (output valid, command, request_size, block_address, input ready);
   modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface bta_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bta_pkg::DATA_W-1:0]  result_address;
   logic                        success;

   modport source (output valid, result_address, success, input ready);
   modport sink   (input valid, result_address, success, output ready);
endinterface

>>> sv/bta_alu.sv
// Shared add/subtract unit of the allocator sequencer; subtract also yields borrow.
// Depends on bta_pkg for the operand structs.
module bta_alu (
   input  bta_pkg::alu_req_type op,
   output bta_pkg::alu_res_type res
);
   logic [bta_pkg::DATA_W:0] sum;

   always_comb begin
      sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {{bta_pkg::DATA_W{1'b0}}, op.sub};
      res.y      = sum[bta_pkg::DATA_W-1:0];
      res.borrow = op.sub & ~sum[bta_pkg::DATA_W];
   end
endmodule

>>> sv/boundary_tag_first_fit_allocator.sv
// Top level of the boundary-tag first-fit allocator: sequencer and tag memory.
// Depends on bta_pkg, bta_if.sv and bta_alu.
//
//  channel | dir | transfer when        | payload
//  req     | in  | req.valid&req.ready  | command, request_size, block_address
//  rsp     | out | rsp.valid&rsp.ready  | result_address, success
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// Allocate steps over the blocks one by one and ends in a split, a whole-block take or a
// no-fit response; free marks the block, then merges left and right. Every cycle is one
// pass through the shared adder and at most one access of the single-port tag memory.
// After reset the memory is cleared and then formatted; writing arena_size launches a
// reformat through the format steps. req.ready is low during all of this and in the
// response step; a response waits in its register while the next item runs.
module boundary_tag_first_fit_allocator (
   input  logic                        clock,
   input  logic                        reset,
   bta_req_if.sink                     req,
   bta_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [bta_pkg::DATA_W-1:0]  csr_wdata
);
   localparam int AW = bta_pkg::ADDR_W;
   localparam int VW = bta_pkg::VAL_W;
   localparam int DW = bta_pkg::DATA_W;

   typedef enum logic [6:0] {
      ST_CLEAR, ST_IDLE, ST_FMT0, ST_FMT1, ST_FMT2, ST_FMT3, ST_FMT4,
      ST_A_RF, ST_A_RS, ST_A_SZ, ST_A_CK, ST_A_SP0, ST_A_SP1,
      ST_A_NX0, ST_A_NX1, ST_A_NX2, ST_A_NX3, ST_A_NX4,
      ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9,
      ST_S10, ST_S11, ST_S12, ST_S13,
      ST_W0, ST_W1, ST_W2, ST_W3, ST_W4,
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
      ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_L8,
      ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_R7, ST_R8, ST_R9,
      ST_R10, ST_R11, ST_RESP
   } state_type;

   state_type state_ff;

   logic [DW-1:0] base_ff;
   logic [VW-1:0] arena_ff;
   logic          fmt_pend_ff;
   logic          fmt_first_ff;
   logic [VW-1:0] fmt_len_ff;
   logic [AW-1:0] clr_cnt_ff;

   logic          cmd_ff;
   logic [VW-1:0] n_ff;
   logic [DW-1:0] blk_ff;
   logic [DW-1:0] f_ff, u_ff, t_ff, v_ff, e_ff, top_ff, p_ff, ps_ff;
   logic [VW-1:0] sz_ff;
   logic          fl_ff;
   logic [DW-1:0] res_addr_ff;
   logic          res_ok_ff;

   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_addr_ff;
   logic          rsp_ok_ff;

   // tag memory
   logic [VW-1:0] tag_mem [bta_pkg::MEM_BYTES];
   logic [VW-1:0] rd_q_ff;
   logic          rd_oob_ff;
   logic [VW-1:0] rdata;
   logic [DW-1:0] rdz;

   bta_pkg::alu_req_type alu_op;
   bta_pkg::alu_res_type alu_res;
   logic          mem_wr, mem_rd;
   logic [VW-1:0] mem_wdata;
   logic          in_range;
   logic [VW-1:0] alen;
   logic          req_take;

   bta_alu u_alu (.op(alu_op), .res(alu_res));

   always_comb begin
      if (arena_ff < bta_pkg::ARENA_MIN)        alen = bta_pkg::ARENA_MIN;
      else if (arena_ff > bta_pkg::ARENA_RESET) alen = bta_pkg::ARENA_RESET;
      else                                      alen = arena_ff;
   end

   assign rdata    = rd_oob_ff ? '0 : rd_q_ff;
   assign rdz      = {{(DW-VW){1'b0}}, rdata};
   assign in_range = (alu_res.y[DW-1:AW] == '0);

   assign req.ready = (state_ff == ST_IDLE) && !fmt_pend_ff;
   assign req_take  = req.valid && req.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_address = rsp_addr_ff;
   assign rsp.success        = rsp_ok_ff;

   function automatic logic [DW-1:0] zx(input logic [VW-1:0] x);
      zx = {{(DW-VW){1'b0}}, x};
   endfunction

   function automatic logic [DW-1:0] k(input int x);
      k = DW'(x);
   endfunction

   // operand selection and memory action per step
   always_comb begin
      alu_op    = '0;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            alu_op.a = {{(DW-AW){1'b0}}, clr_cnt_ff};
            mem_wr   = 1'b1;
         end
         ST_FMT0: begin mem_wr = 1'b1; mem_wdata = VW'(1); end
         ST_FMT1: begin alu_op = '{zx(fmt_len_ff), k(2*bta_pkg::TAG_BYTES), 1'b1}; end
         ST_FMT2: begin alu_op.b = k(1); mem_wr = 1'b1; mem_wdata = u_ff[VW-1:0]; end
         ST_FMT3: begin
            alu_op = '{zx(fmt_len_ff), k(bta_pkg::TAG_BYTES), 1'b1};
            mem_wr = 1'b1; mem_wdata = u_ff[VW-1:0];
         end
         ST_FMT4: begin
            alu_op = '{zx(fmt_len_ff), k(1), 1'b1};
            mem_wr = 1'b1; mem_wdata = VW'(1);
         end
         ST_A_RF:  begin alu_op.a = f_ff; mem_rd = 1'b1; end
         ST_A_RS:  begin alu_op = '{f_ff, k(1), 1'b0}; mem_rd = 1'b1; end
         ST_A_CK:  alu_op = '{zx(sz_ff), zx(n_ff), 1'b1};
         ST_A_SP0: alu_op = '{zx(n_ff), k(2*bta_pkg::TAG_BYTES), 1'b0};
         ST_A_SP1: alu_op = '{t_ff, zx(sz_ff), 1'b1};
         ST_A_NX0: alu_op = '{f_ff, zx(sz_ff), 1'b0};
         ST_A_NX1: alu_op = '{u_ff, zx(n_ff), 1'b0};
         ST_A_NX2: alu_op = '{t_ff, k(1 + bta_pkg::SIZE_BYTES + 3*bta_pkg::TAG_BYTES), 1'b0};
         ST_A_NX3: alu_op = '{zx(alen), t_ff, 1'b1};
         ST_A_NX4: alu_op = '{u_ff, k(2*bta_pkg::TAG_BYTES), 1'b0};
         ST_S0:    alu_op = '{f_ff, zx(sz_ff), 1'b0};
         ST_S1:    alu_op = '{u_ff, k(1 + bta_pkg::SIZE_BYTES), 1'b0};
         ST_S2:    begin alu_op.a = e_ff; mem_wr = 1'b1; mem_wdata = n_ff; end
         ST_S3:    begin alu_op = '{e_ff, k(bta_pkg::SIZE_BYTES), 1'b0}; mem_wr = 1'b1; end
         ST_S4:    alu_op = '{e_ff, zx(n_ff), 1'b1};
         ST_S5:    alu_op = '{u_ff, k(bta_pkg::SIZE_BYTES), 1'b1};
         ST_S6:    begin alu_op.a = top_ff; mem_wr = 1'b1; mem_wdata = n_ff; end
         ST_S7:    begin alu_op = '{top_ff, k(1), 1'b1}; mem_wr = 1'b1; end
         ST_S8:    begin
            alu_op = '{top_ff, k(2), 1'b1}; mem_wr = 1'b1; mem_wdata = VW'(1);
         end
         ST_S9:    alu_op = '{zx(sz_ff), t_ff, 1'b1};
         ST_S10:   begin
            alu_op = '{top_ff, k(2 + bta_pkg::SIZE_BYTES), 1'b1};
            mem_wr = 1'b1; mem_wdata = v_ff[VW-1:0];
         end
         ST_S11:   begin
            alu_op = '{f_ff, k(1), 1'b0}; mem_wr = 1'b1; mem_wdata = v_ff[VW-1:0];
         end
         ST_S12:   alu_op = '{top_ff, k(bta_pkg::SIZE_BYTES), 1'b0};
         ST_S13:   alu_op = '{base_ff, u_ff, 1'b0};
         ST_W0:    begin alu_op.a = f_ff; mem_wr = 1'b1; end
         ST_W1:    alu_op = '{f_ff, zx(sz_ff), 1'b0};
         ST_W2:    begin
            alu_op = '{u_ff, k(1 + 2*bta_pkg::SIZE_BYTES), 1'b0}; mem_wr = 1'b1;
         end
         ST_W3:    alu_op = '{f_ff, k(1 + bta_pkg::SIZE_BYTES), 1'b0};
         ST_W4:    alu_op = '{base_ff, u_ff, 1'b0};
         ST_F0:    alu_op = '{blk_ff, base_ff, 1'b1};
         ST_F1:    begin alu_op = '{p_ff, k(bta_pkg::SIZE_BYTES), 1'b1}; mem_rd = 1'b1; end
         ST_F2:    begin
            alu_op = '{ps_ff, k(1), 1'b1}; mem_wr = 1'b1; mem_wdata = VW'(1);
         end
         ST_F3:    alu_op = '{p_ff, zx(sz_ff), 1'b0};
         ST_F4:    begin
            alu_op = '{e_ff, k(bta_pkg::SIZE_BYTES), 1'b0};
            mem_wr = 1'b1; mem_wdata = VW'(1);
         end
         ST_F5:    begin alu_op = '{ps_ff, k(2), 1'b1}; mem_rd = 1'b1; end
         ST_L0:    begin
            alu_op = '{ps_ff, k(2 + bta_pkg::SIZE_BYTES), 1'b1}; mem_rd = 1'b1;
         end
         ST_L1:    alu_op = '{u_ff, rdz, 1'b1};
         ST_L2:    begin alu_op = '{u_ff, k(bta_pkg::SIZE_BYTES), 1'b1}; mem_rd = 1'b1; end
         ST_L3:    alu_op = '{rdz, zx(sz_ff), 1'b0};
         ST_L4:    alu_op = '{v_ff, k(2*bta_pkg::TAG_BYTES), 1'b0};
         ST_L5:    begin alu_op.a = ps_ff; mem_wr = 1'b1; mem_wdata = v_ff[VW-1:0]; end
         ST_L6:    begin
            alu_op = '{ps_ff, k(1), 1'b1}; mem_wr = 1'b1; mem_wdata = VW'(1);
         end
         ST_L7:    begin alu_op.a = ps_ff; mem_rd = 1'b1; end
         ST_L8:    begin alu_op.a = e_ff; mem_wr = 1'b1; mem_wdata = rdata; end
         ST_R0:    alu_op = '{e_ff, k(bta_pkg::TAG_BYTES), 1'b0};
         ST_R1:    alu_op = '{u_ff, zx(alen), 1'b1};
         ST_R2:    begin alu_op.a = u_ff; mem_rd = 1'b1; end
         ST_R3:    begin alu_op = '{u_ff, k(1), 1'b0}; mem_rd = 1'b1; end
         ST_R4:    alu_op = '{u_ff, rdz, 1'b0};
         ST_R5:    begin alu_op = '{u_ff, k(bta_pkg::SIZE_BYTES), 1'b0}; mem_rd = 1'b1; end
         ST_R6:    begin alu_op.a = ps_ff; mem_rd = 1'b1; end
         ST_R7:    alu_op = '{v_ff, rdz, 1'b0};
         ST_R8:    alu_op = '{v_ff, k(2*bta_pkg::TAG_BYTES), 1'b0};
         ST_R9:    begin alu_op.a = u_ff; mem_wr = 1'b1; mem_wdata = v_ff[VW-1:0]; end
         ST_R10:   begin alu_op.a = u_ff; mem_rd = 1'b1; end
         ST_R11:   begin alu_op.a = ps_ff; mem_wr = 1'b1; mem_wdata = rdata; end
         default: ;
      endcase
   end

   // tag memory: offsets outside the store read as zero and drop writes
   always_ff @(posedge clock) begin
      if (mem_wr && in_range) begin
         tag_mem[alu_res.y[AW-1:0]] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_q_ff   <= tag_mem[alu_res.y[AW-1:0]];
         rd_oob_ff <= !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         arena_ff     <= bta_pkg::ARENA_RESET;
         fmt_pend_ff  <= 1'b1;
         fmt_first_ff <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (&clr_cnt_ff) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (fmt_pend_ff) begin
                  // the power-on layout goes down first so its end tags persist
                  fmt_len_ff   <= fmt_first_ff ? bta_pkg::ARENA_RESET : alen;
                  fmt_first_ff <= 1'b0;
                  if (!fmt_first_ff) fmt_pend_ff <= 1'b0;
                  state_ff <= ST_FMT0;
               end else if (req_take) begin
                  cmd_ff <= req.command;
                  n_ff   <= req.request_size;
                  blk_ff <= req.block_address;
                  f_ff   <= '0;
                  state_ff <= (req.command == bta_pkg::CMD_ALLOC) ? ST_A_RF : ST_F0;
               end
            end
            ST_FMT0: state_ff <= ST_FMT1;
            ST_FMT1: begin u_ff <= alu_res.y; state_ff <= ST_FMT2; end
            ST_FMT2: state_ff <= ST_FMT3;
            ST_FMT3: state_ff <= ST_FMT4;
            ST_FMT4: state_ff <= ST_IDLE;
            // allocate walk
            ST_A_RF: state_ff <= ST_A_RS;
            ST_A_RS: begin fl_ff <= (rdata != '0); state_ff <= ST_A_SZ; end
            ST_A_SZ: begin sz_ff <= rdata; state_ff <= ST_A_CK; end
            ST_A_CK: state_ff <= (fl_ff && !alu_res.borrow) ? ST_A_SP0 : ST_A_NX0;
            ST_A_SP0: begin t_ff <= alu_res.y; state_ff <= ST_A_SP1; end
            ST_A_SP1: state_ff <= alu_res.borrow ? ST_S0 : ST_W0;
            ST_A_NX0: begin u_ff <= alu_res.y; state_ff <= ST_A_NX1; end
            ST_A_NX1: begin t_ff <= alu_res.y; state_ff <= ST_A_NX2; end
            ST_A_NX2: begin t_ff <= alu_res.y; state_ff <= ST_A_NX3; end
            ST_A_NX3: begin
               if (alu_res.borrow) begin
                  res_addr_ff <= '0;
                  res_ok_ff   <= 1'b0;
                  state_ff    <= ST_RESP;
               end else begin
                  state_ff <= ST_A_NX4;
               end
            end
            ST_A_NX4: begin f_ff <= alu_res.y; state_ff <= ST_A_RF; end
            // split: hand out the top part
            ST_S0:  begin u_ff <= alu_res.y; state_ff <= ST_S1; end
            ST_S1:  begin e_ff <= alu_res.y; state_ff <= ST_S2; end
            ST_S2:  state_ff <= ST_S3;
            ST_S3:  state_ff <= ST_S4;
            ST_S4:  begin u_ff <= alu_res.y; state_ff <= ST_S5; end
            ST_S5:  begin top_ff <= alu_res.y; state_ff <= ST_S6; end
            ST_S6:  state_ff <= ST_S7;
            ST_S7:  state_ff <= ST_S8;
            ST_S8:  state_ff <= ST_S9;
            ST_S9:  begin v_ff <= alu_res.y; state_ff <= ST_S10; end
            ST_S10: state_ff <= ST_S11;
            ST_S11: state_ff <= ST_S12;
            ST_S12: begin u_ff <= alu_res.y; state_ff <= ST_S13; end
            ST_S13: begin
               res_addr_ff <= alu_res.y;
               res_ok_ff   <= 1'b1;
               state_ff    <= ST_RESP;
            end
            // whole block taken
            ST_W0: state_ff <= ST_W1;
            ST_W1: begin u_ff <= alu_res.y; state_ff <= ST_W2; end
            ST_W2: state_ff <= ST_W3;
            ST_W3: begin u_ff <= alu_res.y; state_ff <= ST_W4; end
            ST_W4: begin
               res_addr_ff <= alu_res.y;
               res_ok_ff   <= 1'b1;
               state_ff    <= ST_RESP;
            end
            // free: mark, then merge left, then merge right
            ST_F0: begin p_ff <= alu_res.y; state_ff <= ST_F1; end
            ST_F1: begin ps_ff <= alu_res.y; state_ff <= ST_F2; end
            ST_F2: begin sz_ff <= rdata; state_ff <= ST_F3; end
            ST_F3: begin e_ff <= alu_res.y; state_ff <= ST_F4; end
            ST_F4: state_ff <= ST_F5;
            ST_F5: state_ff <= ST_F6;
            ST_F6: state_ff <= (rdata != '0) ? ST_L0 : ST_R0;
            ST_L0: begin u_ff <= alu_res.y; state_ff <= ST_L1; end
            ST_L1: begin u_ff <= alu_res.y; state_ff <= ST_L2; end
            ST_L2: begin ps_ff <= alu_res.y; state_ff <= ST_L3; end
            ST_L3: begin v_ff <= alu_res.y; state_ff <= ST_L4; end
            ST_L4: begin v_ff <= alu_res.y; state_ff <= ST_L5; end
            ST_L5: state_ff <= ST_L6;
            ST_L6: state_ff <= ST_L7;
            ST_L7: state_ff <= ST_L8;
            ST_L8: state_ff <= ST_R0;
            ST_R0: begin u_ff <= alu_res.y; state_ff <= ST_R1; end
            ST_R1: begin
               if (alu_res.borrow) begin
                  state_ff <= ST_R2;
               end else begin
                  res_addr_ff <= '0;
                  res_ok_ff   <= 1'b1;
                  state_ff    <= ST_RESP;
               end
            end
            ST_R2: state_ff <= ST_R3;
            ST_R3: begin
               if (rdata == '0) begin
                  res_addr_ff <= '0;
                  res_ok_ff   <= 1'b1;
                  state_ff    <= ST_RESP;
               end else begin
                  u_ff     <= alu_res.y;
                  state_ff <= ST_R4;
               end
            end
            ST_R4:  begin u_ff <= alu_res.y; state_ff <= ST_R5; end
            ST_R5:  begin u_ff <= alu_res.y; state_ff <= ST_R6; end
            ST_R6:  begin v_ff <= rdz; state_ff <= ST_R7; end
            ST_R7:  begin v_ff <= alu_res.y; state_ff <= ST_R8; end
            ST_R8:  begin v_ff <= alu_res.y; state_ff <= ST_R9; end
            ST_R9:  state_ff <= ST_R10;
            ST_R10: state_ff <= ST_R11;
            ST_R11: begin
               res_addr_ff <= '0;
               res_ok_ff   <= 1'b1;
               state_ff    <= ST_RESP;
            end
            ST_RESP: begin
               // hold until the previous response has been taken
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= res_addr_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (csr_we) begin
            unique case (csr_index)
               bta_pkg::REG_BASE:  base_ff <= csr_wdata;
               bta_pkg::REG_ARENA: begin
                  arena_ff    <= csr_wdata[VW-1:0];
                  fmt_pend_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // failed allocations carry a zero address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_addr_ff == '0)
      else $error("failed allocate with nonzero address");

   // a new response only appears from the response step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("response raised outside response step");

   // no transfer is taken while a reformat is pending
   a_no_take_fmt: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !fmt_pend_ff && state_ff == ST_IDLE)
      else $error("request taken during format");

   // the clearing sweep advances one entry a cycle
   a_clear_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && !(&clr_cnt_ff) |=> clr_cnt_ff == $past(clr_cnt_ff) + AW'(1))
      else $error("clearing sweep skipped");

   // only free operations get past the free entry step
   a_free_cmd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_F0 |-> cmd_ff == bta_pkg::CMD_FREE)
      else $error("free path entered for allocate");

endmodule
